@@ rtl/hte_pkg.sv @@
// Shared constants, operation codes and types for the Huffman table encoder.
`timescale 1ns / 1ps

package hte_pkg;

    // Default configuration
    localparam int SYMBOL_COUNT_DEF = 256;
    localparam int MAX_CODE_LEN_DEF = 32;
    localparam int WORD_BITS_DEF    = 32;

    // Fixed field widths of the item and result words
    localparam int OP_W       = 2;
    localparam int SYMBOL_W   = 8;
    localparam int CODE_IN_W  = 32;
    localparam int LEN_IN_W   = 6;
    localparam int OUT_WORD_W = 32;
    localparam int OUT_BITS_W = 6;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

    // Request handed from the front end to the packer stage
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            hit;   // symbol lies inside the table
    } pack_req_t;

endpackage

@@ rtl/hte_item_if.sv @@
// Input channel: valid/ready handshake carrying one item word.
`timescale 1ns / 1ps

interface hte_item_if;
    logic                          valid;
    logic                          ready;
    logic [hte_pkg::OP_W-1:0]      operation;
    logic [hte_pkg::SYMBOL_W-1:0]  symbol;
    logic [hte_pkg::CODE_IN_W-1:0] code_bits;
    logic [hte_pkg::LEN_IN_W-1:0]  code_length;

    modport source (output valid, operation, symbol, code_bits, code_length, input ready);
    modport sink   (input valid, operation, symbol, code_bits, code_length, output ready);
endinterface

@@ rtl/hte_result_if.sv @@
// Output channel: valid/ready handshake carrying one packed result word.
`timescale 1ns / 1ps

interface hte_result_if;
    logic                           valid;
    logic                           ready;
    logic [hte_pkg::OUT_WORD_W-1:0] packed_word;
    logic [hte_pkg::OUT_BITS_W-1:0] valid_bits;
    logic                           last_of_run;

    modport source (output valid, packed_word, valid_bits, last_of_run, input ready);
    modport sink   (input valid, packed_word, valid_bits, last_of_run, output ready);
endinterface

@@ rtl/hte_code_table.sv @@
// Code table: code and length memories with registered read.
`timescale 1ns / 1ps

module hte_code_table #(
    parameter int SYMBOL_COUNT = hte_pkg::SYMBOL_COUNT_DEF,
    parameter int CODE_W       = hte_pkg::MAX_CODE_LEN_DEF,
    parameter int LEN_W        = 6,
    parameter int ADDR_W       = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] addr,
    input  logic [CODE_W-1:0] wr_code,
    input  logic [LEN_W-1:0]  wr_len,
    output logic [CODE_W-1:0] rd_code,
    output logic [LEN_W-1:0]  rd_len
);

    logic [CODE_W-1:0]       code_mem [SYMBOL_COUNT];
    logic [LEN_W-1:0]        len_mem  [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] written_reg;
    logic [CODE_W-1:0]       rd_code_reg;
    logic [LEN_W-1:0]        rd_len_reg;
    logic                    rd_written_reg;

    // Entry valid flags: an unwritten entry reads as length zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (wr_en)
        begin
            written_reg[addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            code_mem[addr] <= wr_code;
            len_mem[addr]  <= wr_len;
        end
        if (rd_en)
        begin
            rd_code_reg    <= code_mem[addr];
            rd_len_reg     <= len_mem[addr];
            rd_written_reg <= written_reg[addr];
        end
    end

    assign rd_code = rd_code_reg;
    assign rd_len  = rd_written_reg ? rd_len_reg : '0;

endmodule

@@ rtl/hte_packer.sv @@
// Packer stage: appends codes to the pending word and holds the result register.
`timescale 1ns / 1ps

module hte_packer #(
    parameter int WORD_BITS = hte_pkg::WORD_BITS_DEF,
    parameter int CODE_W    = hte_pkg::MAX_CODE_LEN_DEF,
    parameter int LEN_W     = 6
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  hte_pkg::pack_req_t             req,
    output logic                           take_ready,
    input  logic [CODE_W-1:0]              rd_code,
    input  logic [LEN_W-1:0]               rd_len,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [hte_pkg::OUT_WORD_W-1:0] out_word,
    output logic [hte_pkg::OUT_BITS_W-1:0] out_bits
);

    localparam int FILL_W = $clog2(WORD_BITS);
    localparam int TOT_W  = $clog2(WORD_BITS + CODE_W);
    localparam int CNT_W  = $clog2(WORD_BITS + 1);
    localparam int WIDE_W = WORD_BITS + CODE_W;

    logic                     s1_valid_reg;
    hte_pkg::pack_req_t       s1_req_reg;
    logic [WORD_BITS-1:0]     pend_reg, pend_next;
    logic [FILL_W-1:0]        fill_reg, fill_next;
    logic                     oval_reg, oval_next;
    logic [WORD_BITS-1:0]     oword_reg, oword_next;
    logic [CNT_W-1:0]         obits_reg, obits_next;

    logic                     advance;
    logic [CODE_W-1:0]        code_m;
    logic [WIDE_W-1:0]        shifted;
    logic [TOT_W-1:0]         total;
    logic                     emit;
    logic [WORD_BITS+31:0]    word_ext;
    logic [CNT_W+5:0]         bits_ext;

    assign advance    = !oval_reg || out_ready;
    assign take_ready = !s1_valid_reg || advance;

    // Barrel shift the masked code up to the first free bit
    assign code_m  = rd_code & ~({CODE_W{1'b1}} << rd_len);
    assign shifted = WIDE_W'(code_m) << fill_reg;
    assign total   = TOT_W'(fill_reg) + TOT_W'(rd_len);

    always_comb
    begin
        pend_next  = pend_reg;
        fill_next  = fill_reg;
        oword_next = oword_reg;
        obits_next = obits_reg;
        emit       = 1'b0;
        if (s1_valid_reg && advance)
        begin
            unique case (s1_req_reg.op)
                hte_pkg::OP_ENCODE:
                begin
                    if (s1_req_reg.hit && (rd_len != '0))
                    begin
                        if (total >= TOT_W'(WORD_BITS))
                        begin
                            emit       = 1'b1;
                            oword_next = pend_reg | shifted[WORD_BITS-1:0];
                            obits_next = CNT_W'(WORD_BITS);
                            fill_next  = FILL_W'(total - TOT_W'(WORD_BITS));
                            pend_next  = WORD_BITS'(shifted[WORD_BITS +: CODE_W]);
                        end
                        else
                        begin
                            pend_next = pend_reg | shifted[WORD_BITS-1:0];
                            fill_next = FILL_W'(total);
                        end
                    end
                end
                hte_pkg::OP_FLUSH:
                begin
                    if (fill_reg != '0)
                    begin
                        emit       = 1'b1;
                        oword_next = pend_reg;
                        obits_next = CNT_W'(fill_reg);
                        pend_next  = '0;
                        fill_next  = '0;
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
        oval_next = advance ? (s1_valid_reg && emit) : oval_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            oval_reg     <= 1'b0;
            pend_reg     <= '0;
            fill_reg     <= '0;
        end
        else
        begin
            if (take_ready)
            begin
                s1_valid_reg <= accept;
            end
            oval_reg <= oval_next;
            pend_reg <= pend_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg <= req;
        end
        oword_reg <= oword_next;
        obits_reg <= obits_next;
    end

    // Cut the result fields to their port widths
    assign word_ext  = {32'b0, oword_reg};
    assign bits_ext  = {6'b0, obits_reg};
    assign out_valid = oval_reg;
    assign out_word  = word_ext[hte_pkg::OUT_WORD_W-1:0];
    assign out_bits  = bits_ext[hte_pkg::OUT_BITS_W-1:0];

endmodule

@@ rtl/huffman_table_encoder_packer.sv @@
// Top level of the table-driven Huffman encoder with word bit packer.
`timescale 1ns / 1ps

// Table-driven Huffman encoder that packs code bits into words. A load word
// writes the code and length of one symbol into a table memory (lengths are
// saturated to the smaller of MAX_CODE_LEN and WORD_BITS); an encode word
// reads the symbol's entry and appends its code, first code bit lowest, to
// a pending word that fills from bit 0; every word that fills up is sent
// with valid_bits equal to WORD_BITS. A flush word sends the partial word,
// if it holds any bits, and clears it. Symbols with length zero, symbols
// outside the table, empty flushes and operation code 3 send nothing. Each
// item sends at most one word, so last_of_run is always 1. Throughput is
// one item per cycle while the output takes results: the table is written
// and read at the acceptance edge, and the packer then works on the
// registered read data, so a load followed at once by an encode of the
// same symbol sees the new entry. An accepted item passes through the
// stage-one request register and then the result register, which loads
// when the packer advances; a valid result waits there until taken. Input
// ready drops only while a finished result waits on a stalled output. Table
// lengths reset to zero through per-entry valid flags, so no clearing pass
// is needed and items are accepted right after reset.
module huffman_table_encoder_packer #(
    parameter int SYMBOL_COUNT = hte_pkg::SYMBOL_COUNT_DEF,
    parameter int MAX_CODE_LEN = hte_pkg::MAX_CODE_LEN_DEF,
    parameter int WORD_BITS    = hte_pkg::WORD_BITS_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    hte_item_if.sink     item,
    hte_result_if.source result
);

    // Longest code that can be stored and appended in one step
    localparam int LEN_CAP = (MAX_CODE_LEN < WORD_BITS) ? MAX_CODE_LEN : WORD_BITS;
    localparam int CODE_W  = LEN_CAP;
    localparam int LEN_W   = $clog2(LEN_CAP + 1);
    localparam int ADDR_W  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

    logic                   accept;
    logic                   in_range;
    logic                   take_ready;
    logic [LEN_W-1:0]       sat_len;
    logic [CODE_W-1:0]      rd_code;
    logic [LEN_W-1:0]       rd_len;
    hte_pkg::pack_req_t     req;

    assign item.ready = take_ready;
    assign accept     = item.valid && item.ready;

    // Symbols beyond the table are dropped: no write, no read, no output
    assign in_range = {1'b0, item.symbol} < 9'(SYMBOL_COUNT);

    // Saturate the load length to what the table and the word can hold
    assign sat_len = (item.code_length > hte_pkg::LEN_IN_W'(LEN_CAP))
                   ? LEN_W'(LEN_CAP) : LEN_W'(item.code_length);

    assign req.op  = item.operation;
    assign req.hit = in_range;

    hte_code_table #(
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .CODE_W       (CODE_W),
        .LEN_W        (LEN_W),
        .ADDR_W       (ADDR_W)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept && in_range && (item.operation == hte_pkg::OP_LOAD)),
        .rd_en   (accept && in_range && (item.operation == hte_pkg::OP_ENCODE)),
        .addr    (item.symbol[ADDR_W-1:0]),
        .wr_code (item.code_bits[CODE_W-1:0]),
        .wr_len  (sat_len),
        .rd_code (rd_code),
        .rd_len  (rd_len)
    );

    // Packer holds the pending word, the fill count and the result register
    hte_packer #(
        .WORD_BITS (WORD_BITS),
        .CODE_W    (CODE_W),
        .LEN_W     (LEN_W)
    ) u_packer (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .req        (req),
        .take_ready (take_ready),
        .rd_code    (rd_code),
        .rd_len     (rd_len),
        .out_valid  (result.valid),
        .out_ready  (result.ready),
        .out_word   (result.packed_word),
        .out_bits   (result.valid_bits)
    );

    // Every item sends at most one word, so each word closes its run
    assign result.last_of_run = 1'b1;

    // A word always carries at least one bit (the count wraps only at 64)
    a_bits_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> ((WORD_BITS == 64) || (result.valid_bits != '0)))
        else $error("result word sent with zero valid bits");

    // Input stalls only behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> result.valid)
        else $error("input stalled with no result pending");

    // A load never raises a new result
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.operation == hte_pkg::OP_LOAD)) |=> ##1 !$rose(result.valid))
        else $error("load item produced a result word");

endmodule

@@ tb/hte_packer_checker.sv @@
// Checker that predicts and compares the packed words of the Huffman table encoder.
`timescale 1ns / 1ps

module hte_packer_checker (
    input  logic  clk,
    input  logic  rst_n,
    hte_item_if   item,
    hte_result_if result,
    output int    mismatch_count,
    output int    words_due,
    output int    words_checked
);
    import hte_pkg::*;

    typedef struct {
        logic [OUT_WORD_W-1:0] packed_word;
        logic [OUT_BITS_W-1:0] valid_bits;
        logic                  last_of_run;
    } out_word_t;

    logic [CODE_IN_W-1:0]     code_table   [SYMBOL_COUNT_DEF];
    logic [LEN_IN_W-1:0]      length_table [SYMBOL_COUNT_DEF];
    logic [WORD_BITS_DEF-1:0] pending_bits;
    int unsigned              fill;
    out_word_t                words_expected [$];

    task automatic report_mismatch(input string msg);
        $display("%0t ns hte_packer_checker: %s", $time, msg);
        mismatch_count++;
    endtask

    // Mirror the table and the packer for one accepted item word.
    task automatic pack_item(input logic [OP_W-1:0]      op,
                             input logic [SYMBOL_W-1:0]  sym,
                             input logic [CODE_IN_W-1:0] code_in,
                             input logic [LEN_IN_W-1:0]  len_in);
        logic [63:0] code;
        logic [63:0] shifted;
        int unsigned len;
        int unsigned total;
        out_word_t   w;
        case (op)
            OP_LOAD:
            begin
                len = (len_in > MAX_CODE_LEN_DEF) ? MAX_CODE_LEN_DEF : len_in;
                if (len > WORD_BITS_DEF)
                    len = WORD_BITS_DEF;
                code_table[sym]   = code_in;
                length_table[sym] = len[LEN_IN_W-1:0];
            end
            OP_ENCODE:
            begin
                len = 32'(length_table[sym]);
                if (len != 0)
                begin
                    code    = {32'b0, code_table[sym]} & ((64'd1 << len) - 64'd1);
                    shifted = code << fill;
                    total   = fill + len;
                    if (total >= WORD_BITS_DEF)
                    begin
                        w.packed_word = pending_bits | shifted[31:0];
                        w.valid_bits  = OUT_BITS_W'(WORD_BITS_DEF);
                        w.last_of_run = 1'b1;
                        words_expected.push_back(w);
                        fill         = total - WORD_BITS_DEF;
                        pending_bits = shifted[63:32];
                    end
                    else
                    begin
                        pending_bits = pending_bits | shifted[31:0];
                        fill         = total;
                    end
                end
            end
            OP_FLUSH:
            begin
                if (fill != 0)
                begin
                    w.packed_word = pending_bits;
                    w.valid_bits  = OUT_BITS_W'(fill);
                    w.last_of_run = 1'b1;
                    words_expected.push_back(w);
                    pending_bits = '0;
                    fill         = 0;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_word();
        out_word_t w;
        if (words_expected.size() == 0)
        begin
            report_mismatch($sformatf("unexpected word %h, %0d bits",
                                      result.packed_word, result.valid_bits));
            return;
        end
        w = words_expected.pop_front();
        words_checked++;
        if (result.packed_word !== w.packed_word)
            report_mismatch($sformatf("packed_word %h, wanted %h",
                                      result.packed_word, w.packed_word));
        if (result.valid_bits !== w.valid_bits)
            report_mismatch($sformatf("valid_bits %0d, wanted %0d",
                                      result.valid_bits, w.valid_bits));
        if (result.last_of_run !== w.last_of_run)
            report_mismatch($sformatf("last_of_run %b, wanted %b",
                                      result.last_of_run, w.last_of_run));
    endtask

    initial
    begin
        mismatch_count = 0;
        words_due      = 0;
        words_checked  = 0;
    end

    // Inputs only move on the rising edge, so what shows here is what the
    // next rising edge takes. Retire results before adding new ones.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            foreach (length_table[i])
                length_table[i] = '0;
            pending_bits = '0;
            fill         = 0;
            words_expected.delete();
        end
        else
        begin
            if (result.valid && result.ready)
                check_word();
            if (item.valid && item.ready)
                pack_item(item.operation, item.symbol, item.code_bits, item.code_length);
        end
        words_due = words_expected.size();
    end

endmodule

@@ tb/tb_huffman_table_encoder_packer.sv @@
// Testbench top: clock, reset, item stimulus and verdict for the Huffman table encoder.
`timescale 1ns / 1ps

module tb_huffman_table_encoder_packer;
    import hte_pkg::*;

    // Operation code 3 has no name in the package; the block must ignore it.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int LONG_HOLD_CYCLES = 400;
    localparam int PHASE_WORDS      = 160;
    localparam int DRAIN_CYCLES     = 8;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    hte_item_if   item_ch ();
    hte_result_if result_ch ();

    int mismatch_count;
    int words_due;
    int words_checked;

    // Idle and stall odds in percent, set per phase by the stimulus.
    int send_idle_pct = 0;
    int stall_pct     = 0;

    // Long receiver hold: raised by the stimulus, counted down by the sink.
    bit hold_request = 1'b0;
    int hold_left    = 0;

    int n_load    = 0;
    int n_encode  = 0;
    int n_flush   = 0;
    int n_ignored = 0;

    // Symbols loaded with a nonzero length, so encodes mostly hit the table.
    logic [SYMBOL_W-1:0] loaded_syms [$];

    huffman_table_encoder_packer i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    hte_packer_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .item           (item_ch),
        .result         (result_ch),
        .mismatch_count (mismatch_count),
        .words_due      (words_due),
        .words_checked  (words_checked)
    );

    always #5 clk = ~clk;

    // Offer one item word, idling first at the phase's odds, and return on
    // the rising edge that takes it. Ready is sampled at the falling edge,
    // where nothing can move it before the next rising edge.
    task automatic send_word(input logic [OP_W-1:0]      op,
                             input logic [SYMBOL_W-1:0]  sym,
                             input logic [CODE_IN_W-1:0] code,
                             input logic [LEN_IN_W-1:0]  len);
        bit taken;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.operation   <= op;
        item_ch.symbol      <= sym;
        item_ch.code_bits   <= code;
        item_ch.code_length <= len;
        do
        begin
            @(negedge clk);
            taken = item_ch.ready;
            @(posedge clk);
        end
        while (!taken);
        case (op)
            OP_LOAD:   n_load++;
            OP_ENCODE: n_encode++;
            OP_FLUSH:  n_flush++;
            default:   n_ignored++;
        endcase
    endtask

    // One random item: mostly encodes of loaded symbols with table updates
    // and flushes mixed in, plus a little noise (unknown symbols, op 3).
    task automatic random_item();
        int                  pick;
        int                  len_pick;
        logic [SYMBOL_W-1:0] sym;
        logic [LEN_IN_W-1:0] len;
        pick = $urandom_range(99);
        if (pick < 14 || loaded_syms.size() == 0)
        begin
            sym      = SYMBOL_W'($urandom_range(255));
            len_pick = $urandom_range(99);
            if (len_pick < 60)
                len = LEN_IN_W'($urandom_range(1, 12));
            else if (len_pick < 85)
                len = LEN_IN_W'($urandom_range(13, 32));
            else if (len_pick < 93)
                len = LEN_IN_W'($urandom_range(33, 63));
            else
                len = '0;
            send_word(OP_LOAD, sym, $urandom, len);
            if (len != 0)
                loaded_syms.push_back(sym);
        end
        else if (pick < 84)
            send_word(OP_ENCODE, loaded_syms[$urandom_range(loaded_syms.size() - 1)],
                      $urandom, LEN_IN_W'($urandom_range(63)));
        else if (pick < 91)
            send_word(OP_FLUSH, SYMBOL_W'($urandom_range(255)), $urandom,
                      LEN_IN_W'($urandom_range(63)));
        else if (pick < 96)
            send_word(OP_ENCODE, SYMBOL_W'($urandom_range(255)), $urandom,
                      LEN_IN_W'($urandom_range(63)));
        else
            send_word(OP_UNUSED, SYMBOL_W'($urandom_range(255)), $urandom,
                      LEN_IN_W'($urandom_range(63)));
    endtask

    // Run random items until the phase has added this many real items.
    task automatic random_phase(input int count);
        int stop_at;
        stop_at = n_load + n_encode + n_flush + count;
        while (n_load + n_encode + n_flush < stop_at)
            random_item();
    endtask

    // Result sink: random stalls at the phase's odds, or a long hold when
    // the stimulus asks for one.
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left    = LONG_HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Stimulus and verdict.
    initial
    begin
        item_ch.valid       = 1'b0;
        item_ch.operation   = OP_LOAD;
        item_ch.symbol      = '0;
        item_ch.code_bits   = '0;
        item_ch.code_length = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, back to back: empty flush, unloaded symbol, op 3,
        // saturated and zero lengths, code bits above the length, a word
        // that fills exactly, words that straddle the boundary, and a load
        // followed at once by an encode of the same symbol.
        send_word(OP_FLUSH,  8'd0,   32'h0000_0000, 6'd0);
        send_word(OP_ENCODE, 8'd0,   32'h0000_0000, 6'd0);
        send_word(OP_UNUSED, 8'hFF,  32'hFFFF_FFFF, 6'h3F);
        send_word(OP_LOAD,   8'd0,   32'hFFFF_FFFF, 6'd32);
        send_word(OP_LOAD,   8'd255, 32'hFFFF_FFFE, 6'd1);
        send_word(OP_LOAD,   8'd128, 32'hA5A5_5A5A, 6'd63);
        send_word(OP_LOAD,   8'd7,   32'h0000_0005, 6'd33);
        send_word(OP_LOAD,   8'd1,   32'hDEAD_BEEF, 6'd0);
        send_word(OP_ENCODE, 8'd255, 32'h0000_0000, 6'd0);
        send_word(OP_ENCODE, 8'd0,   32'h0000_0000, 6'd0);
        send_word(OP_FLUSH,  8'd0,   32'h0000_0000, 6'd0);
        send_word(OP_FLUSH,  8'd0,   32'h0000_0000, 6'd0);
        send_word(OP_ENCODE, 8'd128, 32'h0000_0000, 6'd0);
        send_word(OP_ENCODE, 8'd1,   32'h0000_0000, 6'd0);
        send_word(OP_LOAD,   8'd42,  32'h0000_0003, 6'd2);
        send_word(OP_ENCODE, 8'd42,  32'h0000_0000, 6'd0);
        send_word(OP_ENCODE, 8'd7,   32'h0000_0000, 6'd0);
        send_word(OP_LOAD,   8'd42,  32'h5555_5555, 6'd31);
        send_word(OP_ENCODE, 8'd42,  32'h0000_0000, 6'd0);
        send_word(OP_ENCODE, 8'd255, 32'h0000_0000, 6'd0);
        send_word(OP_LOAD,   8'd3,   32'h0000_0000, 6'd5);
        send_word(OP_ENCODE, 8'd3,   32'h0000_0000, 6'd0);
        send_word(OP_FLUSH,  8'd0,   32'h0000_0000, 6'd0);
        loaded_syms = '{8'd0, 8'd255, 8'd128, 8'd7, 8'd42, 8'd3};

        // Random phases: no idling, idle sender, stalling receiver, both.
        random_phase(PHASE_WORDS);
        send_idle_pct = 63;
        stall_pct     = 0;
        random_phase(PHASE_WORDS);
        send_idle_pct = 0;
        stall_pct     = 63;
        random_phase(PHASE_WORDS);
        send_idle_pct = 37;
        stall_pct     = 37;
        random_phase(PHASE_WORDS);

        // Hold the receiver off for a long stretch and stream full-length
        // codes so the block backs up and drops its input ready.
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_request  = 1'b1;
        send_word(OP_LOAD, 8'd200, $urandom, 6'd32);
        loaded_syms.push_back(8'd200);
        repeat (48)
            send_word(OP_ENCODE, 8'd200, $urandom, LEN_IN_W'($urandom_range(63)));

        // Pause the sender until every pending word has come out.
        item_ch.valid <= 1'b0;
        while (words_due != 0)
            @(posedge clk);

        send_idle_pct = 37;
        stall_pct     = 37;
        random_phase(40);
        send_word(OP_FLUSH, 8'd0, 32'h0000_0000, 6'd0);

        // Drain: stop offering, keep the sink open, then allow for latency.
        item_ch.valid <= 1'b0;
        stall_pct = 0;
        while (words_due != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d loads, %0d encodes, %0d flushes, %0d op-3 items; %0d words checked",
                 n_load, n_encode, n_flush, n_ignored, words_checked);
        $display("Idle mixes: none, sender, receiver, both; plus a %0d-cycle receiver hold",
                 LONG_HOLD_CYCLES);
        if (mismatch_count == 0 && words_due == 0)
            $display("tb_huffman_table_encoder_packer: clean");
        else
            $display("tb_huffman_table_encoder_packer: errors");
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        #2_000_000;
        $display("tb_huffman_table_encoder_packer: errors");
        $finish;
    end

endmodule
